[rtl/wtm_pkg.sv]
// shared types and constants for the wildcard tuple match table
`default_nettype none

package wtm_pkg;

  localparam int ValueW      = 16;
  localparam int NumValues   = 8;
  localparam int DefMaxArity = 8;
  localparam int DefEntries  = 64;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 4;
  localparam int SizeW       = 4;

  localparam logic [ValueW-1:0] Wildcard = {ValueW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegTupleSize    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRelationKind = 1'b1;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdCheck  = 1'b1
  } cmd_e;

  typedef enum logic {
    RelSupport  = 1'b0,
    RelConflict = 1'b1
  } rel_e;

  // control that travels with an item along the row
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic hit;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/wtm_cell.sv]
// one table cell: holds one stored tuple and one stage of the item row
`default_nettype none

module wtm_cell #(
  parameter int MAX_ARITY = wtm_pkg::DefMaxArity,
  parameter int CNT_W     = 7,
  parameter int POS       = 0
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      vld_i,
  input  wire wtm_pkg::ctrl_t                            ctrl_i,
  input  wire logic [CNT_W-1:0]                          idx_i,
  input  wire logic [MAX_ARITY-1:0][wtm_pkg::ValueW-1:0] vals_i,
  input  wire logic [MAX_ARITY-1:0]                      mask_i,
  output logic                                           vld_o,
  output wtm_pkg::ctrl_t                                 ctrl_o,
  output logic [CNT_W-1:0]                               idx_o,
  output logic [MAX_ARITY-1:0][wtm_pkg::ValueW-1:0]      vals_o
);
  import wtm_pkg::*;

  localparam logic [CNT_W-1:0] Pos = CNT_W'(POS);

  logic [MAX_ARITY-1:0][ValueW-1:0] entry_q;
  logic                             vld_q;
  ctrl_t                            ctrl_q, ctrl_d;
  logic [CNT_W-1:0]                 idx_q;
  logic [MAX_ARITY-1:0][ValueW-1:0] vals_q;
  logic [MAX_ARITY-1:0]             lane_ok;
  logic                             entry_hit;
  logic                             wr_en;

  always_comb begin
    for (int j = 0; j < MAX_ARITY; j++) begin
      lane_ok[j] = !mask_i[j] || (entry_q[j] == Wildcard) || (vals_i[j] == Wildcard)
                   || (entry_q[j] == vals_i[j]);
    end
  end

  // the index carried by a check is the fill count seen when it came in
  assign entry_hit = (ctrl_i.cmd == CmdCheck) && (Pos < idx_i) && (&lane_ok);
  assign wr_en     = en_i && vld_i && (ctrl_i.cmd == CmdInsert) && !ctrl_i.full
                     && (idx_i == Pos);

  always_comb begin
    ctrl_d     = ctrl_i;
    ctrl_d.hit = ctrl_i.hit || entry_hit;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= vals_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_d;
      idx_q  <= idx_i;
      vals_q <= vals_i;
    end
  end

  assign vld_o  = vld_q;
  assign ctrl_o = ctrl_q;
  assign idx_o  = idx_q;
  assign vals_o = vals_q;

endmodule

`default_nettype wire

[rtl/wildcard_tuple_match_table.sv]
// each item passes through the row of ENTRIES cells, then its result is held in the output register
// throughput: one item per cycle while the output is not stalled; items move along the row one cell a cycle
// an output stall freezes the whole row, so items never overtake one another
// reset clears the fill count, the valid flags and the config (tuple_size 1, support)
// stored tuples are not cleared; only entries below the fill count are ever compared
`default_nettype none

module wildcard_tuple_match_table #(
  parameter int MAX_ARITY = wtm_pkg::DefMaxArity,
  parameter int ENTRIES   = wtm_pkg::DefEntries
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wtm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [wtm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           command_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_0_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_1_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_2_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_3_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_4_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_5_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_6_i,
  input  wire logic signed [wtm_pkg::ValueW-1:0] value_7_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                is_present_o,
  output logic                                is_valid_o,
  output logic                                status_o
);
  import wtm_pkg::*;

  localparam int CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

  logic [SizeW-1:0] tuple_size_q;
  rel_e             relation_kind_q;
  logic [CntW-1:0]  count_q;
  logic [SizeW-1:0] cmp_width;
  logic [MAX_ARITY-1:0] mask;

  logic [NumValues-1:0][ValueW-1:0] all_vals;
  logic                             adv;
  logic                             in_xfer;
  cmd_e                             in_cmd;
  ctrl_t                            in_ctrl;

  logic [ENTRIES:0]                            ch_vld;
  ctrl_t [ENTRIES:0]                           ch_ctrl;
  logic [ENTRIES:0][CntW-1:0]                  ch_idx;
  logic [ENTRIES:0][MAX_ARITY-1:0][ValueW-1:0] ch_vals;

  logic out_valid_q, out_present_q, out_valid_bit_q, out_status_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuple_size_q    <= SizeW'(1);
      relation_kind_q <= RelSupport;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTupleSize:    tuple_size_q    <= cfg_data_i;
        RegRelationKind: relation_kind_q <= rel_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (tuple_size_q == '0) begin
      cmp_width = SizeW'(1);
    end else if (tuple_size_q > SizeW'(MAX_ARITY)) begin
      cmp_width = SizeW'(MAX_ARITY);
    end else begin
      cmp_width = tuple_size_q;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_ARITY; j++) begin
      mask[j] = SizeW'(j) < cmp_width;
    end
  end

  // row moves whenever the output register can take the last stage
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_xfer    = in_valid_i && adv;
  assign in_cmd     = cmd_e'(command_i);

  assign all_vals[0] = value_0_i;
  assign all_vals[1] = value_1_i;
  assign all_vals[2] = value_2_i;
  assign all_vals[3] = value_3_i;
  assign all_vals[4] = value_4_i;
  assign all_vals[5] = value_5_i;
  assign all_vals[6] = value_6_i;
  assign all_vals[7] = value_7_i;

  always_comb begin
    in_ctrl      = '0;
    in_ctrl.cmd  = in_cmd;
    in_ctrl.full = (in_cmd == CmdInsert) && (count_q == Full);
    in_ctrl.hit  = 1'b0;
  end

  // an insert takes its slot on entry, so later checks already count it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_xfer && (in_cmd == CmdInsert) && !in_ctrl.full) begin
      count_q <= count_q + CntW'(1);
    end
  end

  assign ch_vld[0]  = in_valid_i;
  assign ch_ctrl[0] = in_ctrl;
  assign ch_idx[0]  = count_q;
  assign ch_vals[0] = all_vals[MAX_ARITY-1:0];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    wtm_cell #(
      .MAX_ARITY (MAX_ARITY),
      .CNT_W     (CntW),
      .POS       (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (ch_vld[g]),
      .ctrl_i (ch_ctrl[g]),
      .idx_i  (ch_idx[g]),
      .vals_i (ch_vals[g]),
      .mask_i (mask),
      .vld_o  (ch_vld[g+1]),
      .ctrl_o (ch_ctrl[g+1]),
      .idx_o  (ch_idx[g+1]),
      .vals_o (ch_vals[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ch_vld[ENTRIES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ch_ctrl[ENTRIES].cmd == CmdCheck) begin
        out_present_q   <= ch_ctrl[ENTRIES].hit;
        out_valid_bit_q <= (relation_kind_q == RelSupport) ? ch_ctrl[ENTRIES].hit
                                                          : !ch_ctrl[ENTRIES].hit;
        out_status_q    <= 1'b0;
      end else begin
        out_present_q   <= 1'b0;
        out_valid_bit_q <= 1'b0;
        out_status_q    <= ch_ctrl[ENTRIES].full;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_present_o = out_present_q;
  assign is_valid_o   = out_valid_bit_q;
  assign status_o     = out_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("fill count beyond table size");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(count_q))
    else $error("fill count moved without an input transfer");

  a_drop_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !is_present_o && !is_valid_o)
    else $error("dropped insert reports a match");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_cmd == CmdInsert) && (count_q != Full) |=> count_q != '0)
    else $error("stored insert did not raise the fill count");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking bench for the wildcard tuple match table: directed rows, then random phases
module tb_top;
  import wtm_pkg::*;

  localparam int MaxArity   = DefMaxArity;
  localparam int Entries    = DefEntries;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 75;
  localparam int QuietLimit = 5000;
  localparam int NumRows    = 25;

  // tuple_size per random phase, phase 0 in the low nibble
  localparam logic [NumPhases-1:0][SizeW-1:0] PhaseSizes =
    {4'd8, 4'd2, 4'd5, 4'd15, 4'd0, 4'd3, 4'd8, 4'd1};

  typedef logic [NumValues-1:0][ValueW-1:0] tuple_t;

  typedef struct packed {
    logic present;
    logic valid;
    logic status;
  } verdict_t;

  localparam verdict_t InsertOk        = '{present: 1'b0, valid: 1'b0, status: 1'b0};
  localparam verdict_t NoMatchSupport  = '{present: 1'b0, valid: 1'b0, status: 1'b0};
  localparam verdict_t NoMatchConflict = '{present: 1'b0, valid: 1'b1, status: 1'b0};

  typedef enum logic {
    RowItem,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    cmd_e                 cmd;
    tuple_t               vals;
    logic                 pinned;
    verdict_t             want;
  } row_t;

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  cmd_e                cmd       = CmdCheck;
  tuple_t              vals      = '0;
  logic                out_stall = 1'b0;
  logic                pinned    = 1'b0;
  verdict_t            pinned_want = '0;

  logic in_stall, out_valid, is_present, is_valid, status;

  // bench copy of the table
  tuple_t          tuple_mem [Entries];
  int              fill_count = 0;
  logic [SizeW-1:0] size_reg  = 4'd1;
  rel_e            rel_reg   = RelSupport;

  verdict_t expected_q [$];
  row_t     plan [NumRows];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_inserts = 0;
  int n_dropped = 0;
  int n_checks  = 0;
  int n_hits    = 0;
  int n_writes  = 0;

  wildcard_tuple_match_table #(
    .MAX_ARITY (MaxArity),
    .ENTRIES   (Entries)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (cmd),
    .value_0_i    (vals[0]),
    .value_1_i    (vals[1]),
    .value_2_i    (vals[2]),
    .value_3_i    (vals[3]),
    .value_4_i    (vals[4]),
    .value_5_i    (vals[5]),
    .value_6_i    (vals[6]),
    .value_7_i    (vals[7]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .is_present_o (is_present),
    .is_valid_o   (is_valid),
    .status_o     (status)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // insert stores all positions; check scans entries below the fill count
  function automatic verdict_t lookup_or_store(cmd_e c, tuple_t q);
    verdict_t r;
    int       width;
    int       e;
    int       j;
    logic     entry_hit;
    r = '0;
    if (c == CmdInsert) begin
      if (fill_count >= Entries) begin
        r.status = 1'b1;
      end else begin
        tuple_mem[fill_count] = q;
        fill_count++;
      end
    end else begin
      if (size_reg == 0) width = 1;
      else if (size_reg > MaxArity) width = MaxArity;
      else width = size_reg;
      for (e = 0; e < fill_count; e++) begin
        entry_hit = 1'b1;
        for (j = 0; j < width; j++) begin
          if (tuple_mem[e][j] != Wildcard && q[j] != Wildcard && tuple_mem[e][j] != q[j])
            entry_hit = 1'b0;
        end
        if (entry_hit) r.present = 1'b1;
      end
      r.valid = (rel_reg == RelSupport) ? r.present : !r.present;
    end
    return r;
  endfunction

  function automatic tuple_t tup(int v0, int v1, int v2, int v3,
                                 int v4, int v5, int v6, int v7);
    tuple_t r;
    r[0] = v0[15:0]; r[1] = v1[15:0]; r[2] = v2[15:0]; r[3] = v3[15:0];
    r[4] = v4[15:0]; r[5] = v5[15:0]; r[6] = v6[15:0]; r[7] = v7[15:0];
    return r;
  endfunction

  function automatic row_t item_row(cmd_e c, tuple_t v, logic pin, verdict_t w);
    row_t r;
    r = '0;
    r.kind = RowItem;
    r.cmd = c;
    r.vals = v;
    r.pinned = pin;
    r.want = w;
    return r;
  endfunction

  function automatic row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    row_t r;
    r = '0;
    r.kind = RowWrite;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // small values give frequent matches, the range up to 32767 exercises the low 15 bits
  function automatic logic [ValueW-1:0] fresh_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return Wildcard;
    if (r < 50) return ValueW'($urandom_range(0, 3));
    if (r < 55) return 16'h7fff;
    return ValueW'($urandom_range(0, 32767));
  endfunction

  function automatic tuple_t make_tuple();
    tuple_t q;
    for (int j = 0; j < NumValues; j++) q[j] = fresh_value();
    return q;
  endfunction

  // mostly a perturbed copy of a stored tuple so hits and near misses both occur
  function automatic tuple_t make_query();
    tuple_t q;
    tuple_t base;
    int     r;
    if (fill_count == 0 || $urandom_range(0, 99) >= 60) return make_tuple();
    base = tuple_mem[$urandom_range(0, fill_count - 1)];
    for (int j = 0; j < NumValues; j++) begin
      r = $urandom_range(0, 99);
      if (r < 15) q[j] = Wildcard;
      else if (r < 30) q[j] = fresh_value();
      else q[j] = base[j];
    end
    return q;
  endfunction

  task automatic send(cmd_e c, tuple_t v, logic pin, verdict_t w);
    cmd <= c;
    vals <= v;
    pinned <= pin;
    pinned_want <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // scoreboard: results are popped before new items are predicted
  always @(posedge clk_i) begin
    verdict_t want;
    verdict_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (is_present !== want.present) begin
            $error("is_present: expected %0b, got %0b", want.present, is_present);
            errors++;
          end
          if (is_valid !== want.valid) begin
            $error("is_valid: expected %0b, got %0b", want.valid, is_valid);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        got = lookup_or_store(cmd, vals);
        if (cmd == CmdInsert) begin
          n_inserts++;
          if (got.status) n_dropped++;
        end else begin
          n_checks++;
          if (got.present) n_hits++;
        end
        expected_q.insert(expected_q.size(), pinned ? pinned_want : got);
      end
      if (cfg_we) begin
        n_writes++;
        case (cfg_idx)
          RegTupleSize:    size_reg = cfg_data;
          RegRelationKind: rel_reg = rel_e'(cfg_data[0]);
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int   ph;
    int   k;
    logic hold;
    cmd_e c;
    plan = '{
      item_row(CmdCheck, tup(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NoMatchSupport),
      item_row(CmdCheck, tup(-1, -1, -1, -1, -1, -1, -1, -1), 1'b1, NoMatchSupport),
      write_row(RegRelationKind, 4'b0001),
      item_row(CmdCheck, tup(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
               1'b1, NoMatchConflict),
      write_row(RegTupleSize, 4'd8),
      item_row(CmdInsert, tup(0, 1, 2, 3, 4, 5, 6, 7), 1'b1, InsertOk),
      item_row(CmdInsert, tup(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
               1'b1, InsertOk),
      // stored wildcards in the upper half
      item_row(CmdInsert, tup(5, 5, 5, 5, -1, -1, -1, -1), 1'b1, InsertOk),
      item_row(CmdCheck, tup(0, 1, 2, 3, 4, 5, 6, 7), 1'b0, '0),
      item_row(CmdCheck, tup(0, 1, 2, 3, 4, 5, 6, 8), 1'b0, '0),
      item_row(CmdCheck, tup(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0),
      item_row(CmdCheck, tup(5, 5, 5, 5, 9, 9, 9, 9), 1'b0, '0),
      item_row(CmdCheck, tup(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0), 1'b0, '0),
      // support again, with the ignored upper data bits set
      write_row(RegRelationKind, 4'b1110),
      item_row(CmdCheck, tup(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
               1'b0, '0),
      item_row(CmdCheck, tup(0, 1, 2, 3, 4, 5, 6, 8), 1'b0, '0),
      // size zero compares one position
      write_row(RegTupleSize, 4'd0),
      item_row(CmdCheck, tup(0, 100, 100, 100, 100, 100, 100, 100), 1'b0, '0),
      item_row(CmdCheck, tup(1, 100, 100, 100, 100, 100, 100, 100), 1'b0, '0),
      // oversize saturates to the full arity
      write_row(RegTupleSize, 4'd15),
      item_row(CmdCheck, tup(0, 1, 2, 3, 4, 5, 6, -1), 1'b0, '0),
      item_row(CmdCheck, tup(5, 5, 5, -1, 0, 0, 0, 0), 1'b0, '0),
      write_row(RegTupleSize, 4'd4),
      item_row(CmdCheck, tup(0, 1, 2, 3, 9, 9, 9, 9), 1'b0, '0),
      item_row(CmdCheck, tup(-1, -1, -1, 4, 0, 0, 0, 0), 1'b0, '0)
    };

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        drain(2);
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send(plan[i].cmd, plan[i].vals, plan[i].pinned, plan[i].want);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      drain(2);
      write_reg(RegTupleSize, PhaseSizes[ph]);
      write_reg(RegRelationKind, {3'($urandom_range(0, 7)), ph[0]});
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (k = 0; k < PhaseItems; k++) begin
        // once, hold the sender until the table has answered everything
        hold = (ph == 1 && k == PhaseItems / 2);
        if (hold) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          while (expected_q.size() != 0) @(posedge clk_i);
        end else begin
          while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk_i);
          end
        end
        c = ($urandom_range(0, 99) < 15) ? CmdInsert : CmdCheck;
        send(c, (c == CmdInsert) ? make_tuple() : make_query(), 1'b0, '0);
      end
    end

    drain(Entries + 4);
    $display("run covered %0d inserts (%0d dropped on a full table) and %0d checks (%0d matched)",
             n_inserts, n_dropped, n_checks, n_hits);
    $display("%0d register writes over %0d random phases with mixed idling and stalls",
             n_writes, NumPhases);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wtm_pkg.sv
rtl/wtm_cell.sv
rtl/wildcard_tuple_match_table.sv
verif/tb_top.sv
